// ===== rtl/psg_pkg.sv =====
// ----------------------------------------------------------------------------
// psg_pkg
// Shared widths, register codes and controller/datapath interface types for
// the permutation sequence generator.
// ----------------------------------------------------------------------------
`default_nettype none

package psg_pkg;

    // element value width, packed arrangement width, index width
    localparam int VAL_W   = 4;
    localparam int PACK_W  = 48;
    localparam int INDEX_W = 29;
    localparam int SIZE_W  = 4;

    // register map: register index is paddr[2]
    localparam logic [0:0] REG_SET_SIZE = 1'b0;
    localparam logic [SIZE_W-1:0] SET_SIZE_RESET = 4'd4;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clear;       // back to the identity and the first index
        logic walk_start;  // point the walk at the deepest level
        logic rd;          // read the two swap positions
        logic rd_next;     // with rd: take the next choice at this level
        logic wr_a;        // write the first half of a swap
        logic wr_b;        // write the second half of a swap
        logic step_up;     // move the walk one level up
        logic bump;        // advance the permutation index
        logic load_out;    // capture the current arrangement as a result
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic fits;    // the next choice at this level is still in range
        logic at_top;  // the walk is at level zero
        logic last;    // the current arrangement is the final one
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/psg_datapath.sv =====
// ----------------------------------------------------------------------------
// psg_datapath
// Arrangement memory, per-level choice stack, walk pointer, index counter and
// the result registers. Every step is ordered by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_datapath
    import psg_pkg::*;
#(
    parameter int MAX_SIZE = 12
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [SIZE_W-1:0]   set_size,
    input  wire dp_cmd_t             cmd,
    output dp_stat_t                 stat,
    output logic      [PACK_W-1:0]   perm_packed,
    output logic      [INDEX_W-1:0]  perm_index,
    output logic                     last_of_run
);

    localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int N_W   = $clog2(MAX_SIZE + 1);

    logic [N_W-1:0]     size_eff;
    logic [N_W-1:0]     size_m1;
    logic [IDX_W-1:0]   depth_reg;
    logic [IDX_W-1:0]   choice_reg [MAX_SIZE];
    logic [MAX_SIZE-1:0] valid_reg;
    logic [VAL_W-1:0]   mem [MAX_SIZE];
    logic [PACK_W-1:0]  mirror_reg;
    logic [PACK_W-1:0]  ident_packed;
    logic [PACK_W-1:0]  masked_packed;
    logic [INDEX_W-1:0] count_reg;
    logic [IDX_W-1:0]   addr_a_reg;
    logic [IDX_W-1:0]   addr_b_reg;
    logic [VAL_W-1:0]   raw_a_reg;
    logic [VAL_W-1:0]   raw_b_reg;
    logic               vld_a_reg;
    logic               vld_b_reg;
    logic [VAL_W-1:0]   data_a;
    logic [VAL_W-1:0]   data_b;
    logic [IDX_W-1:0]   cur_choice;
    logic [N_W-1:0]     next_choice_w;
    logic [IDX_W-1:0]   rd_addr_b;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [VAL_W-1:0]   wr_data;
    logic               last;
    logic [PACK_W-1:0]  perm_packed_reg;
    logic [INDEX_W-1:0] perm_index_reg;
    logic               last_of_run_reg;

    // element count, clipped to the largest supported set
    always_comb
    begin
        if (set_size > SIZE_W'(MAX_SIZE))
            size_eff = N_W'(MAX_SIZE);
        else
            size_eff = N_W'(set_size);
    end

    assign size_m1 = size_eff - N_W'(1);

    // identity order, one value per position
    always_comb
    begin
        ident_packed = '0;
        for (int i = 0; i < MAX_SIZE; i++)
            ident_packed[VAL_W*i +: VAL_W] = VAL_W'(i + 1);
    end

    // choice at the current level and the one after it
    assign cur_choice    = choice_reg[depth_reg];
    assign next_choice_w = N_W'(cur_choice) + N_W'(1);
    assign rd_addr_b     = cmd.rd_next ? next_choice_w[IDX_W-1:0] : cur_choice;

    // swap write port: first beat writes position a with b, second writes b with a
    assign wr_en   = cmd.wr_a | cmd.wr_b;
    assign wr_addr = cmd.wr_a ? addr_a_reg : addr_b_reg;
    assign wr_data = cmd.wr_a ? data_b : data_a;

    // entries never written since the last clear hold the identity
    assign data_a = vld_a_reg ? raw_a_reg : VAL_W'(addr_a_reg) + VAL_W'(1);
    assign data_b = vld_b_reg ? raw_b_reg : VAL_W'(addr_b_reg) + VAL_W'(1);

    // arrangement memory, one write and two registered reads
    // a read during the second write of an undo only meets that write when the
    // swap was a no-op, so the old contents equal the new ones
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd)
        begin
            raw_a_reg  <= mem[depth_reg];
            raw_b_reg  <= mem[rd_addr_b];
            vld_a_reg  <= valid_reg[depth_reg];
            vld_b_reg  <= valid_reg[rd_addr_b];
            addr_a_reg <= depth_reg;
            addr_b_reg <= rd_addr_b;
        end
    end

    // valid bits and the packed copy of the arrangement
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            mirror_reg <= ident_packed;
        end
        else if (cmd.clear)
        begin
            valid_reg  <= '0;
            mirror_reg <= ident_packed;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
            for (int i = 0; i < MAX_SIZE; i++)
            begin
                if (wr_addr == IDX_W'(i))
                    mirror_reg[VAL_W*i +: VAL_W] <= wr_data;
            end
        end
    end

    // choice stack, walk pointer and index counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < MAX_SIZE; e++)
                choice_reg[e] <= IDX_W'(e);
            depth_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.clear)
        begin
            for (int e = 0; e < MAX_SIZE; e++)
                choice_reg[e] <= IDX_W'(e);
            depth_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.walk_start)
                depth_reg <= size_m1[IDX_W-1:0];
            else if (cmd.step_up)
                depth_reg <= depth_reg - IDX_W'(1);
            if (cmd.rd_next)
            begin
                for (int e = 0; e < MAX_SIZE; e++)
                begin
                    if (IDX_W'(e) == depth_reg)
                        choice_reg[e] <= next_choice_w[IDX_W-1:0];
                    else if (IDX_W'(e) > depth_reg)
                        choice_reg[e] <= IDX_W'(e);
                end
            end
            if (cmd.bump)
                count_reg <= count_reg + INDEX_W'(1);
        end
    end

    // final arrangement: every level sits on its last choice
    always_comb
    begin
        last = 1'b1;
        for (int d = 0; d < MAX_SIZE; d++)
        begin
            if ((N_W'(d) < size_eff) && (N_W'(choice_reg[d]) != size_m1))
                last = 1'b0;
        end
    end

    // positions beyond the set read as zero
    always_comb
    begin
        masked_packed = '0;
        for (int i = 0; i < MAX_SIZE; i++)
        begin
            if (N_W'(i) < size_eff)
                masked_packed[VAL_W*i +: VAL_W] = mirror_reg[VAL_W*i +: VAL_W];
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            perm_packed_reg <= masked_packed;
            perm_index_reg  <= count_reg;
            last_of_run_reg <= last;
        end
    end

    assign stat.fits   = (next_choice_w < size_eff);
    assign stat.at_top = (depth_reg == '0);
    assign stat.last   = last;

    assign perm_packed = perm_packed_reg;
    assign perm_index  = perm_index_reg;
    assign last_of_run = last_of_run_reg;

endmodule

`default_nettype wire

// ===== rtl/psg_controller.sv =====
// ----------------------------------------------------------------------------
// psg_controller
// State machine that takes request beats, walks the choice levels through
// the datapath and hands results to the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_controller
    import psg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    input  wire logic     restart,
    output logic          req_stall,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    input  wire logic     cfg_wr,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_READ   = 7'b0000010,
        ST_UNDO_A = 7'b0000100,
        ST_UNDO_B = 7'b0001000,
        ST_SWAP_A = 7'b0010000,
        ST_SWAP_B = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   started_reg;
    logic   started_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    // next state and datapath commands
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        started_next   = started_reg;
        rsp_valid_next = rsp_valid_reg & rsp_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_wr)
                begin
                    cmd.clear    = 1'b1;
                    started_next = 1'b0;
                end
                else if (req_valid)
                begin
                    if (restart || !started_reg)
                    begin
                        cmd.clear    = 1'b1;
                        started_next = 1'b1;
                        state_next   = ST_EMIT;
                    end
                    else if (stat.last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_UNDO_A;
            end
            ST_UNDO_A:
            begin
                cmd.wr_a   = 1'b1;
                state_next = ST_UNDO_B;
            end
            ST_UNDO_B:
            begin
                cmd.wr_b = 1'b1;
                if (stat.fits)
                begin
                    cmd.rd      = 1'b1;
                    cmd.rd_next = 1'b1;
                    cmd.bump    = 1'b1;
                    state_next  = ST_SWAP_A;
                end
                else if (stat.at_top)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.step_up = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_SWAP_A:
            begin
                cmd.wr_a   = 1'b1;
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B:
            begin
                cmd.wr_b   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.load_out   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            started_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE) | cfg_wr;
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/permutation_sequence_generator_top.sv =====
// ----------------------------------------------------------------------------
// permutation_sequence_generator_top
// Lists the permutations of 1..n in recursive swap-and-restore order, one
// per request beat, with a running index and a last flag.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall) carries restart: 1 answers with the
//   identity at index zero, 0 asks for the next permutation. Each request
//   beat yields exactly one response beat on rsp_valid/rsp_stall carrying
//   perm_packed (position i in bits 4i+3..4i), perm_index and last_of_run.
//   set_size is written over the APB port at address 0 and restarts the run.
// Operation:
//   A next-permutation request unwinds the choice levels from the deepest
//   one up; each level costs a read and then two swap writes in the
//   single-write arrangement memory, and the new choice is swapped in
//   with two more writes before the emit step. First, restart and wrap
//   requests go straight to the emit step. One request is worked at a
//   time; the next is taken as soon as the result sits in the response
//   register, even if that register is stalled.
// Reset:
//   set_size returns to 4 and the next request answers with the identity.
//   A stalled response holds its beat; the block then waits in its emit
//   step before overwriting it.
// ----------------------------------------------------------------------------
`default_nettype none

module permutation_sequence_generator_top
    import psg_pkg::*;
#(
    parameter int MAX_SIZE = 12
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic               restart,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output logic      [PACK_W-1:0]  perm_packed,
    output logic      [INDEX_W-1:0] perm_index,
    output logic                    last_of_run
);

    logic [SIZE_W-1:0] set_size_reg;
    logic              cfg_wr;
    dp_cmd_t           cmd;
    dp_stat_t          stat;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2:2] == REG_SET_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            set_size_reg <= SET_SIZE_RESET;
        else if (cfg_wr)
            set_size_reg <= pwdata[SIZE_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2:2] == REG_SET_SIZE)
            prdata[SIZE_W-1:0] = set_size_reg;
    end

    // control
    psg_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .restart   (restart),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cfg_wr    (cfg_wr),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    psg_datapath #(
        .MAX_SIZE (MAX_SIZE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .set_size    (set_size_reg),
        .cmd         (cmd),
        .stat        (stat),
        .perm_packed (perm_packed),
        .perm_index  (perm_index),
        .last_of_run (last_of_run)
    );

    // a taken request always makes the block go busy in the cycle after
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken without the block going busy");

    // a waiting response is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |-> !cmd.load_out)
        else $error("stalled response overwritten");

    // an empty set always answers with the empty arrangement at index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (set_size_reg == '0))
            |-> (perm_packed == '0) && (perm_index == '0) && last_of_run)
        else $error("empty set gave a non-empty answer");

endmodule

`default_nettype wire

// ===== verif/tb_permutation_sequence_generator_top.sv =====
// ----------------------------------------------------------------------------
// tb_permutation_sequence_generator_top
// Self-checking bench for the permutation sequence generator. A short table
// of directed requests covers the empty set, one and two elements, the full
// and oversized set, restarts and wrap-around. Random phases follow, each
// with a fresh set_size written over APB. A swap-and-restore predictor inside
// the bench tracks every request beat, and each response beat is compared
// field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_permutation_sequence_generator_top
    import psg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SIZE     = 12;
    localparam int RANDOM_ITEMS = 1450;
    localparam int DIRECTED_N   = 25;

    // byte addresses on the register port
    localparam logic [2:0] ADDR_SET_SIZE = {REG_SET_SIZE, 2'b00};
    localparam logic [2:0] ADDR_SPARE    = {~REG_SET_SIZE, 2'b00};

    typedef struct packed {
        logic [PACK_W-1:0]  arrangement;
        logic [INDEX_W-1:0] seq_index;
        logic               is_last;
    } perm_beat_t;

    typedef struct packed {
        bit                 write_size;
        logic [31:0]        size_word;
        logic               restart;
        bit                 typed;
        logic [PACK_W-1:0]  want_order;
        logic [INDEX_W-1:0] want_index;
        logic               want_last;
    } dir_row_t;

    // directed requests: a size write first where flagged
    localparam dir_row_t DIRECTED_ROWS [0:DIRECTED_N-1] = '{
        '{1'b0, 32'h0,         1'b0, 1'b1, 48'h4321,         29'd0, 1'b0},
        '{1'b0, 32'h0,         1'b0, 1'b0, 48'h0,            29'd0, 1'b0},
        '{1'b0, 32'h0,         1'b1, 1'b1, 48'h4321,         29'd0, 1'b0},
        '{1'b1, 32'h0,         1'b0, 1'b1, 48'h0,            29'd0, 1'b1},
        '{1'b0, 32'h0,         1'b0, 1'b1, 48'h0,            29'd0, 1'b1},
        '{1'b0, 32'h0,         1'b1, 1'b1, 48'h0,            29'd0, 1'b1},
        '{1'b1, 32'h1,         1'b0, 1'b1, 48'h1,            29'd0, 1'b1},
        '{1'b0, 32'h0,         1'b0, 1'b1, 48'h1,            29'd0, 1'b1},
        '{1'b1, 32'h2,         1'b0, 1'b1, 48'h21,           29'd0, 1'b0},
        '{1'b0, 32'h0,         1'b0, 1'b1, 48'h12,           29'd1, 1'b1},
        '{1'b0, 32'h0,         1'b0, 1'b1, 48'h21,           29'd0, 1'b0},
        '{1'b1, 32'hC,         1'b0, 1'b1, 48'hCBA987654321, 29'd0, 1'b0},
        '{1'b0, 32'h0,         1'b0, 1'b0, 48'h0,            29'd0, 1'b0},
        '{1'b0, 32'h0,         1'b0, 1'b0, 48'h0,            29'd0, 1'b0},
        '{1'b0, 32'h0,         1'b0, 1'b0, 48'h0,            29'd0, 1'b0},
        '{1'b0, 32'h0,         1'b1, 1'b1, 48'hCBA987654321, 29'd0, 1'b0},
        '{1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1, 48'hCBA987654321, 29'd0, 1'b0},
        '{1'b0, 32'h0,         1'b0, 1'b0, 48'h0,            29'd0, 1'b0},
        '{1'b1, 32'h5A5A_A5F3, 1'b0, 1'b1, 48'h321,          29'd0, 1'b0},
        '{1'b0, 32'h0,         1'b0, 1'b0, 48'h0,            29'd0, 1'b0},
        '{1'b0, 32'h0,         1'b0, 1'b0, 48'h0,            29'd0, 1'b0},
        '{1'b0, 32'h0,         1'b0, 1'b0, 48'h0,            29'd0, 1'b0},
        '{1'b0, 32'h0,         1'b0, 1'b0, 48'h0,            29'd0, 1'b0},
        '{1'b0, 32'h0,         1'b0, 1'b0, 48'h0,            29'd0, 1'b0},
        '{1'b0, 32'h0,         1'b0, 1'b0, 48'h0,            29'd0, 1'b0}
    };

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               req_valid;
    logic               req_stall;
    logic               restart;
    logic               rsp_valid;
    logic               rsp_stall;
    logic [PACK_W-1:0]  perm_packed;
    logic [INDEX_W-1:0] perm_index;
    logic               last_of_run;

    // permutations still owed by the block, oldest first
    perm_beat_t pending_perms [$];
    int         mismatch_count;
    bit         steady;

    // predictor state
    logic [3:0]         gen_size;
    logic [3:0]         gen_order [MAX_SIZE];
    logic [3:0]         gen_pick  [MAX_SIZE];
    logic [INDEX_W-1:0] gen_index;
    bit                 gen_started;

    permutation_sequence_generator_top #(
        .MAX_SIZE (MAX_SIZE)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .restart     (restart),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .perm_packed (perm_packed),
        .perm_index  (perm_index),
        .last_of_run (last_of_run)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // oversized settings clamp to the full set
    function automatic int active_size();
        return (int'(gen_size) > MAX_SIZE) ? MAX_SIZE : int'(gen_size);
    endfunction

    // identity order, every level choosing itself, index zero
    function automatic void rewind_sequence();
        for (int d = 0; d < MAX_SIZE; d++)
        begin
            gen_order[d] = 4'(d + 1);
            gen_pick[d]  = 4'(d);
        end
        gen_index = '0;
    endfunction

    function automatic void swap_slots(input int a, input int b);
        logic [3:0] t;
        t            = gen_order[a];
        gen_order[a] = gen_order[b];
        gen_order[b] = t;
    endfunction

    // final order: every level has taken its last choice
    function automatic bit order_is_final(input int n);
        for (int d = 0; d < n; d++)
            if (int'(gen_pick[d]) != n - 1)
                return 1'b0;
        return 1'b1;
    endfunction

    // unwind from the deepest level, undo its swap, take the next choice
    function automatic void advance_sequence(input int n);
        int d;
        int c;
        if (order_is_final(n))
        begin
            rewind_sequence();
            return;
        end
        for (int k = n; k > 0; k--)
        begin
            d = k - 1;
            c = int'(gen_pick[d]);
            swap_slots(d, c);
            c++;
            if (c < n)
            begin
                gen_pick[d] = 4'(c);
                swap_slots(d, c);
                for (int e = d + 1; e < MAX_SIZE; e++)
                    gen_pick[e] = 4'(e);
                gen_index = gen_index + 1'b1;
                return;
            end
        end
        rewind_sequence();
    endfunction

    function automatic perm_beat_t predict_permutation(input logic rs);
        perm_beat_t beat;
        int         n;
        n = active_size();
        if (rs || !gen_started)
        begin
            rewind_sequence();
            gen_started = 1'b1;
        end
        else
        begin
            advance_sequence(n);
        end
        beat.arrangement = '0;
        for (int i = 0; i < n; i++)
            beat.arrangement[4*i +: 4] = gen_order[i];
        beat.seq_index = gen_index;
        beat.is_last   = order_is_final(n);
        return beat;
    endfunction

    function automatic void check_field(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------------

    // a setup phase, then an access phase held until pready, then back to idle
    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] data, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // size write restarts the sequence; read back the stored nibble
    task automatic write_set_size(input logic [31:0] word);
        logic [31:0] rdata;
        apb_access(1'b1, ADDR_SET_SIZE, word, rdata);
        gen_size    = word[3:0];
        gen_started = 1'b0;
        rewind_sequence();
        apb_access(1'b0, ADDR_SET_SIZE, 32'h0, rdata);
        check_field("set_size readback", {60'h0, word[3:0]}, rdata);
    endtask

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    task automatic send_request(input logic rs, input bit typed, input perm_beat_t want);
        int         gap;
        perm_beat_t beat;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        restart   <= rs;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        beat = predict_permutation(rs);
        pending_perms.push_back(typed ? want : beat);
    endtask

    // stop sending and wait for every owed beat
    task automatic finish_requests();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_perms.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // response side: check each beat, then stall at random after it
    // ------------------------------------------------------------------------
    initial
    begin
        int         stall_left;
        perm_beat_t want;
        perm_beat_t got;
        stall_left = 0;
        rsp_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                got.arrangement = perm_packed;
                got.seq_index   = perm_index;
                got.is_last     = last_of_run;
                if (pending_perms.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected beat, expected none, actual %h %h %b",
                             $time, got.arrangement, got.seq_index, got.is_last);
                end
                else
                begin
                    want = pending_perms.pop_front();
                    check_field("perm_packed", want.arrangement, got.arrangement);
                    check_field("perm_index", want.seq_index, got.seq_index);
                    check_field("last_of_run", want.is_last, got.is_last);
                end
                stall_left = steady ? 0 : $urandom_range(0, 4);
            end
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        perm_beat_t  want;
        logic [31:0] word;
        logic [31:0] rdata;
        int          sent;
        int          phase;
        int          span;
        int          pick;

        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_valid      = 1'b0;
        restart        = 1'b0;
        rst_n          = 1'b0;
        steady         = 1'b0;
        mismatch_count = 0;
        gen_size       = SET_SIZE_RESET;
        gen_started    = 1'b0;
        rewind_sequence();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DIRECTED_N; r++)
        begin
            if (DIRECTED_ROWS[r].write_size)
            begin
                finish_requests();
                write_set_size(DIRECTED_ROWS[r].size_word);
            end
            want.arrangement = DIRECTED_ROWS[r].want_order;
            want.seq_index   = DIRECTED_ROWS[r].want_index;
            want.is_last     = DIRECTED_ROWS[r].want_last;
            send_request(DIRECTED_ROWS[r].restart, DIRECTED_ROWS[r].typed, want);
        end

        // random phases, mostly small sets so that wrap-around comes often
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            finish_requests();
            pick = $urandom_range(0, 9);
            word = $urandom;
            if (pick < 7)
                word[3:0] = 4'($urandom_range(0, 5));
            else if (pick < 9)
                word[3:0] = 4'($urandom_range(6, 11));
            else
                word[3:0] = 4'($urandom_range(12, 15));
            steady = ($urandom_range(0, 3) == 0);
            write_set_size(word);
            span = $urandom_range(20, 80);
            for (int j = 0; j < span; j++)
            begin
                send_request($urandom_range(0, 29) == 0, 1'b0, want);
                sent++;
                // drain mid-phase; a write to the spare address must not restart
                if (j == span / 2 && phase % 5 == 1)
                begin
                    finish_requests();
                    apb_access(1'b1, ADDR_SPARE, $urandom, rdata);
                end
            end
            phase++;
        end

        finish_requests();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
